FILE: rtl/sgs_pkg.sv
// ---------------------------------------------------------------------------
// sgs_pkg
// Shared types and constants of the streaming 3x3 Scharr gradient core.
// ---------------------------------------------------------------------------
package sgs_pkg;

   localparam int PIX_W       = 8;
   localparam int COL_W       = 10;
   localparam int ROW_W       = 12;
   localparam int WID_W       = 11;
   localparam int SUM_W       = 12;
   localparam int DIF_W       = 9;
   localparam int GRAD_W      = 13;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int COL_LIMIT   = 1024;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int SLOT_N      = 4;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [ROW_W-1:0] HEIGHT_RESET = 12'd480;

   typedef struct packed {
      logic [WID_W-1:0] frame_width;
      logic [ROW_W-1:0] frame_height;
   } cfg_type;

   // one classified pixel with its vertical pass already done
   typedef struct packed {
      logic [SUM_W-1:0] vsum;
      logic [DIF_W-1:0] vdiff;
      logic [SUM_W-1:0] lsum;
      logic             has_above;
      logic             last_row;
      logic             last_col;
      logic             col_ge1;
      logic             col_eq1;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } entry_type;

endpackage

FILE: rtl/sgs_front.sv
// ---------------------------------------------------------------------------
// sgs_front
// Accepts pixels, tracks column and row, reads and updates the two line
// stores and forms the vertical sums and differences of each column.
// ---------------------------------------------------------------------------
module sgs_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sgs_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sgs_pkg::PIX_W-1:0]     req_pixel,
   output logic                          push_valid,
   input  logic                          push_ready,
   output sgs_pkg::entry_type            push_entry
);
   import sgs_pkg::*;

   localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WLIM = (MAX_WIDTH < COL_LIMIT) ? MAX_WIDTH : COL_LIMIT;

   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               s0_valid_ff, s0_valid_in;
   logic [PIX_W-1:0]   s0_pixel_ff;
   logic [COL_W-1:0]   s0_col_ff;
   logic [ROW_W-1:0]   s0_row_ff;
   logic               s0_col_ok_ff;
   logic               s0_has_above_ff, s0_two_above_ff;
   logic               s0_last_row_ff, s0_last_col_ff;
   logic [2*PIX_W-1:0] mem_rd_ff;

   logic [WID_W-1:0]   w_lo, w_eff;
   logic [ROW_W-1:0]   h_eff;
   logic               last_col, last_row, col_ok, accept;
   logic               need_push, s0_adv;
   logic [PIX_W-1:0]   above, prev, up, nb;
   logic [SUM_W-1:0]   up_plus, vsum, lsum;
   logic [DIF_W-1:0]   vdiff;

   always_comb begin
      w_lo     = (cfg.frame_width < WID_W'(2)) ? WID_W'(2) : cfg.frame_width;
      w_eff    = (w_lo > WID_W'(WLIM)) ? WID_W'(WLIM) : w_lo;
      h_eff    = (cfg.frame_height == '0) ? ROW_W'(1) : cfg.frame_height;
      last_col = {1'b0, col_ff} >= (w_eff - WID_W'(1));
      last_row = row_ff >= (h_eff - ROW_W'(1));
      col_ok   = int'(col_ff) < MAX_WIDTH;
   end

   assign need_push = s0_has_above_ff || s0_last_row_ff;
   assign s0_adv    = s0_valid_ff && (!need_push || push_ready);
   assign req_ready = !s0_valid_ff || s0_adv;
   assign accept    = req_valid && req_ready;

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      s0_valid_in = s0_valid_ff;
      if (s0_adv) begin
         s0_valid_in = 1'b0;
      end
      if (accept) begin
         s0_valid_in = 1'b1;
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s0_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_pixel_ff      <= req_pixel;
         s0_col_ff        <= col_ff;
         s0_row_ff        <= row_ff;
         s0_col_ok_ff     <= col_ok;
         s0_has_above_ff  <= row_ff >= ROW_W'(1);
         s0_two_above_ff  <= row_ff >= ROW_W'(2);
         s0_last_row_ff   <= last_row;
         s0_last_col_ff   <= last_col;
      end
   end

   // line store: upper byte older row, lower byte newer row
   always_ff @(posedge clock) begin
      if (accept && col_ok) begin
         mem_rd_ff <= line_mem[AW'(col_ff)];
      end
      if (s0_adv && s0_col_ok_ff) begin
         line_mem[AW'(s0_col_ff)] <= {prev, s0_pixel_ff};
      end
   end

   always_comb begin
      above   = s0_col_ok_ff ? mem_rd_ff[2*PIX_W-1:PIX_W] : '0;
      prev    = s0_col_ok_ff ? mem_rd_ff[PIX_W-1:0] : '0;
      up      = s0_two_above_ff ? above : s0_pixel_ff;
      nb      = s0_has_above_ff ? prev : s0_pixel_ff;
      up_plus = SUM_W'(up) + SUM_W'(s0_pixel_ff);
      vsum    = (up_plus << 1) + up_plus
              + (SUM_W'(prev) << 3) + (SUM_W'(prev) << 1);
      lsum    = (SUM_W'(nb) << 2) + (SUM_W'(nb) << 1)
              + (SUM_W'(s0_pixel_ff) << 3) + (SUM_W'(s0_pixel_ff) << 1);
      vdiff   = DIF_W'({1'b0, s0_pixel_ff}) - DIF_W'({1'b0, up});
   end

   assign push_valid = s0_valid_ff && need_push;

   always_comb begin
      push_entry.vsum      = vsum;
      push_entry.vdiff     = vdiff;
      push_entry.lsum      = lsum;
      push_entry.has_above = s0_has_above_ff;
      push_entry.last_row  = s0_last_row_ff;
      push_entry.last_col  = s0_last_col_ff;
      push_entry.col_ge1   = s0_col_ff >= COL_W'(1);
      push_entry.col_eq1   = s0_col_ff == COL_W'(1);
      push_entry.col       = s0_col_ff;
      push_entry.row       = s0_row_ff;
   end

`ifndef ASSERT_OFF
   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff && !s0_adv |=> $stable(mem_rd_ff))
      else $error("line store read data changed under a stalled pixel");
`endif

endmodule

FILE: rtl/sgs_queue.sv
// ---------------------------------------------------------------------------
// sgs_queue
// Short first-in first-out queue between the front and back parts.
// ---------------------------------------------------------------------------
module sgs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  sgs_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop_ready,
   output sgs_pkg::entry_type pop_entry
);
   import sgs_pkg::*;

   entry_type         q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push, pop;

   assign push_ready = cnt_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> cnt_ff == $past(cnt_ff) + QCNT_W'($past(push))
                                  - QCNT_W'($past(pop)))
      else $error("queue count lost a transaction");
`endif

endmodule

FILE: rtl/sgs_back.sv
// ---------------------------------------------------------------------------
// sgs_back
// Runs the horizontal pass: keeps the column windows and sends out up to
// four gradient results per queued pixel, one per cycle unless rsp stalls.
// ---------------------------------------------------------------------------
module sgs_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  sgs_pkg::entry_type                pop_entry,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [sgs_pkg::GRAD_W-1:0] rsp_grad_x,
   output logic signed [sgs_pkg::GRAD_W-1:0] rsp_grad_y,
   output logic [sgs_pkg::COL_W-1:0]         rsp_out_col,
   output logic [sgs_pkg::ROW_W-1:0]         rsp_out_row,
   output logic                              rsp_frame_done
);
   import sgs_pkg::*;

   localparam logic [1:0] SLOT_VERT_PREV = 2'd0;
   localparam logic [1:0] SLOT_VERT_EDGE = 2'd1;
   localparam logic [1:0] SLOT_LAST_PREV = 2'd2;
   localparam logic [1:0] SLOT_LAST_EDGE = 2'd3;

   entry_type         cur_ff;
   logic              cur_valid_ff, cur_valid_in;
   logic [SLOT_N-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0]  vsum_ff [3];
   logic [SUM_W-1:0]  vsum_in [3];
   logic [DIF_W-1:0]  vdiff_ff [3];
   logic [DIF_W-1:0]  vdiff_in [3];
   logic [SUM_W-1:0]  lsum_ff [3];
   logic [SUM_W-1:0]  lsum_in [3];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [GRAD_W-1:0] gx_ff, gy_ff;
   logic [COL_W-1:0]  ocol_ff;
   logic [ROW_W-1:0]  orow_ff;
   logic              done_ff;

   logic [1:0]        sel;
   logic [SLOT_N-1:0] sel_bit, rem_after, load_mask;
   logic              out_take, emit, free, load, use_vert, pair;
   logic [SUM_W-1:0]  w0, w1, w2, sl, sr;
   logic [DIF_W-1:0]  dl, dr, dm;
   logic signed [GRAD_W:0] dl_x, dr_x, dm_x, dsum, gy_full;
   logic [GRAD_W-1:0] gx, gy;
   logic [COL_W-1:0]  ocol;
   logic [ROW_W-1:0]  orow;

   always_comb begin
      case (1'b1)
         rem_ff[SLOT_VERT_PREV]: sel = SLOT_VERT_PREV;
         rem_ff[SLOT_VERT_EDGE]: sel = SLOT_VERT_EDGE;
         rem_ff[SLOT_LAST_PREV]: sel = SLOT_LAST_PREV;
         default:                sel = SLOT_LAST_EDGE;
      endcase
      sel_bit = SLOT_N'(1) << sel;
   end

   assign out_take  = !rsp_valid_ff || rsp_ready;
   assign emit      = cur_valid_ff && (rem_ff != '0) && out_take;
   assign rem_after = emit ? (rem_ff & ~sel_bit) : rem_ff;
   assign free      = !cur_valid_ff || (rem_after == '0);
   assign pop_ready = free;
   assign load      = pop_valid && free;

   always_comb begin
      load_mask[SLOT_VERT_PREV] = pop_entry.has_above && pop_entry.col_ge1;
      load_mask[SLOT_VERT_EDGE] = pop_entry.has_above && pop_entry.last_col;
      load_mask[SLOT_LAST_PREV] = pop_entry.last_row && pop_entry.col_ge1;
      load_mask[SLOT_LAST_EDGE] = pop_entry.last_row && pop_entry.last_col;
   end

   always_comb begin
      cur_valid_in = free ? load : cur_valid_ff;
      rem_in       = load ? load_mask : rem_after;
      vsum_in      = vsum_ff;
      vdiff_in     = vdiff_ff;
      lsum_in      = lsum_ff;
      if (load && pop_entry.has_above) begin
         vsum_in[0]  = vsum_ff[1];
         vsum_in[1]  = vsum_ff[2];
         vsum_in[2]  = pop_entry.vsum;
         vdiff_in[0] = vdiff_ff[1];
         vdiff_in[1] = vdiff_ff[2];
         vdiff_in[2] = pop_entry.vdiff;
      end
      if (load && pop_entry.last_row) begin
         lsum_in[0] = lsum_ff[1];
         lsum_in[1] = lsum_ff[2];
         lsum_in[2] = pop_entry.lsum;
      end
   end

   // slot operands: prev slots use left/centre/right, mirrored at column 0; edge slots mirror
   always_comb begin
      use_vert = (sel == SLOT_VERT_PREV) || (sel == SLOT_VERT_EDGE);
      pair     = (sel == SLOT_VERT_PREV) || (sel == SLOT_LAST_PREV);
      w0       = use_vert ? vsum_ff[0] : lsum_ff[0];
      w1       = use_vert ? vsum_ff[1] : lsum_ff[1];
      w2       = use_vert ? vsum_ff[2] : lsum_ff[2];
      sl       = pair ? (cur_ff.col_eq1 ? w2 : w0) : w1;
      sr       = pair ? w2 : w1;
      dl       = pair ? (cur_ff.col_eq1 ? vdiff_ff[2] : vdiff_ff[0]) : vdiff_ff[1];
      dr       = pair ? vdiff_ff[2] : vdiff_ff[1];
      dm       = pair ? vdiff_ff[1] : vdiff_ff[2];
      dl_x     = {{(GRAD_W+1-DIF_W){dl[DIF_W-1]}}, dl};
      dr_x     = {{(GRAD_W+1-DIF_W){dr[DIF_W-1]}}, dr};
      dm_x     = {{(GRAD_W+1-DIF_W){dm[DIF_W-1]}}, dm};
      dsum     = dl_x + dr_x;
      gy_full  = (dsum <<< 1) + dsum + (dm_x <<< 3) + (dm_x <<< 1);
      gx       = {1'b0, sr} - {1'b0, sl};
      gy       = use_vert ? gy_full[GRAD_W-1:0] : '0;
      ocol     = pair ? cur_ff.col - COL_W'(1) : cur_ff.col;
      orow     = use_vert ? cur_ff.row - ROW_W'(1) : cur_ff.row;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         vsum_ff      <= '{default: '0};
         vdiff_ff     <= '{default: '0};
         lsum_ff      <= '{default: '0};
      end else begin
         cur_valid_ff <= cur_valid_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
         vsum_ff      <= vsum_in;
         vdiff_ff     <= vdiff_in;
         lsum_ff      <= lsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= pop_entry;
      end
      if (emit) begin
         gx_ff   <= gx;
         gy_ff   <= gy;
         ocol_ff <= ocol;
         orow_ff <= orow;
         done_ff <= sel == SLOT_LAST_EDGE;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_grad_x     = $signed(gx_ff);
   assign rsp_grad_y     = $signed(gy_ff);
   assign rsp_out_col    = ocol_ff;
   assign rsp_out_row    = orow_ff;
   assign rsp_frame_done = done_ff;

`ifndef ASSERT_OFF
   a_rem_owner: assert property (@(posedge clock) disable iff (reset)
      rem_ff != '0 |-> cur_valid_ff)
      else $error("pending results without a current pixel");

   a_done_flat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> gx_ff == '0 && gy_ff == '0)
      else $error("last gradient of frame is not flat");
`endif

endmodule

FILE: rtl/scharr_gradient_stream_core.sv
// ---------------------------------------------------------------------------
// scharr_gradient_stream_core
// Streaming 3x3 Scharr gradient: raster pixels in, horizontal and vertical
// derivatives tagged with column and row out.
// ---------------------------------------------------------------------------
//  channel  | ports                                   | carries
//  req      | req_valid/req_ready, req_pixel          | one gray pixel
//  rsp      | rsp_valid/rsp_ready, rsp_grad_x/y,      | one gradient result
//           | rsp_out_col, rsp_out_row, rsp_frame_done|
//  csr      | csr_valid/csr_ready, csr_index,         | register write
//           | csr_wdata                               |
//
//  one pixel per cycle in while the queue has room; results leave the output
//  register at one per cycle unless rsp stalls, up to four for a pixel on the
//  last row's final column; a pixel passes the front stage, queue, back load
//  and result registers to rsp; results trail their pixel by a row and a column
//  reset: synchronous, clears counts, windows and queue; width 640, height 480
//  the line store needs no clearing pass; csr writes are always taken
//  a stalled rsp backs up into the queue and then holds req_ready low
module scharr_gradient_stream_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sgs_pkg::PIX_W-1:0]             req_pixel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [sgs_pkg::GRAD_W-1:0]     rsp_grad_x,
   output logic signed [sgs_pkg::GRAD_W-1:0]     rsp_grad_y,
   output logic [sgs_pkg::COL_W-1:0]             rsp_out_col,
   output logic [sgs_pkg::ROW_W-1:0]             rsp_out_row,
   output logic                                  rsp_frame_done,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sgs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sgs_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import sgs_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_ready, pop_valid, pop_ready;
   entry_type push_entry, pop_entry;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FRAME_WIDTH:  cfg_in.frame_width  = csr_wdata[WID_W-1:0];
            REG_FRAME_HEIGHT: cfg_in.frame_height = csr_wdata[ROW_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= WIDTH_RESET;
         cfg_ff.frame_height <= HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sgs_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_pixel  (req_pixel),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   sgs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   sgs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_entry      (pop_entry),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_grad_x     (rsp_grad_x),
      .rsp_grad_y     (rsp_grad_y),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming 3x3 Scharr gradient core. Frames of
// raster pixels are pushed through the req channel while a pixel-level
// gradient predictor tracks line stores, vertical windows and the raster
// position; every rsp transaction is compared field by field in order.
// Covers tiny frames, one-row frames, mirrored borders, register values out
// of range and random frames with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_top;
   import sgs_pkg::*;

   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_ITEMS = 420;

   typedef struct packed {
      logic [GRAD_W-1:0] grad_x;
      logic [GRAD_W-1:0] grad_y;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic              last;
   } grad_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [PIX_W-1:0]         req_pixel = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [GRAD_W-1:0] rsp_grad_x;
   logic signed [GRAD_W-1:0] rsp_grad_y;
   logic [COL_W-1:0]         rsp_out_col;
   logic [ROW_W-1:0]         rsp_out_row;
   logic                     rsp_frame_done;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   // predictor state
   logic [WID_W-1:0] cfg_width  = WIDTH_RESET;
   logic [ROW_W-1:0] cfg_height = HEIGHT_RESET;
   logic [7:0]       row_above_mem [COL_LIMIT];
   logic [7:0]       row_prev_mem  [COL_LIMIT];
   int               sum_win [3]      = '{0, 0, 0};
   int               diff_win [3]     = '{0, 0, 0};
   int               edge_sum_win [3] = '{0, 0, 0};
   int               col_pos = 0;
   int               row_pos = 0;

   grad_result_type  grad_expect [$];
   grad_result_type  next_grad;
   int               error_count = 0;
   int               pixel_count = 0;
   int               cycle_count = 0;
   int               rsp_hold = 0;
   bit               req_gaps_on = 1'b1;
   bit               rsp_stalls_on = 1'b1;

   scharr_gradient_stream_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_grad_x     (rsp_grad_x),
      .rsp_grad_y     (rsp_grad_y),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_done (rsp_frame_done),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin
      for (int i = 0; i < COL_LIMIT; i++) begin
         row_above_mem[i] = '0;
         row_prev_mem[i]  = '0;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void push_grad(input int s_left, input int s_right, input int d_left,
                                     input int d_mid, input int d_right, input int col,
                                     input int row, input bit last);
      grad_result_type g;
      int              gx;
      int              gy;
      gx = s_right - s_left;
      gy = (d_left + d_right) * 3 + d_mid * 10;
      g.grad_x = gx[GRAD_W-1:0];
      g.grad_y = gy[GRAD_W-1:0];
      g.col    = col[COL_W-1:0];
      g.row    = row[ROW_W-1:0];
      g.last   = last;
      grad_expect.push_back(g);
   endfunction

   function automatic void predict_gradients(input logic [PIX_W-1:0] pix);
      int p, w, h, c, y, above, prev, up, nb, l;
      bit last_col, last_row;
      p = pix;
      w = cfg_width;
      h = cfg_height;
      c = col_pos;
      y = row_pos;
      above = row_above_mem[c];
      prev  = row_prev_mem[c];
      if (w < 2) w = 2;
      if (w > COL_LIMIT) w = COL_LIMIT;
      if (h < 1) h = 1;
      last_col = c >= w - 1;
      last_row = y >= h - 1;
      l = (c == 1) ? 2 : 0;

      // row above the current one, current row below it
      if (y >= 1) begin
         up = (y >= 2) ? above : p;
         sum_win  = '{sum_win[1], sum_win[2], (up + p) * 3 + prev * 10};
         diff_win = '{diff_win[1], diff_win[2], p - up};
         if (c >= 1)
            push_grad(sum_win[l], sum_win[2], diff_win[l], diff_win[1], diff_win[2],
                      c - 1, y - 1, 1'b0);
         if (last_col)
            push_grad(sum_win[1], sum_win[1], diff_win[1], diff_win[2], diff_win[1],
                      c, y - 1, 1'b0);
      end

      // last row mirrors onto the row above it, zero vertical difference
      if (last_row) begin
         nb = (y >= 1) ? prev : p;
         edge_sum_win = '{edge_sum_win[1], edge_sum_win[2], nb * 6 + p * 10};
         if (c >= 1)
            push_grad(edge_sum_win[l], edge_sum_win[2], 0, 0, 0, c - 1, y, 1'b0);
         if (last_col)
            push_grad(edge_sum_win[1], edge_sum_win[1], 0, 0, 0, c, y, 1'b1);
      end

      row_above_mem[c] = prev[7:0];
      row_prev_mem[c]  = pix;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : ((y + 1) & 12'hFFF);
      end else begin
         col_pos = (c + 1) & 10'h3FF;
      end
   endfunction

   task automatic check_field(input string field_name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d (col %0d row %0d)",
                  $time, field_name, want, got, next_grad.col, next_grad.row);
      end
   endtask

   // prediction on accepted pixels, comparison on accepted results
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         predict_gradients(req_pixel);
      if (!reset && rsp_valid && rsp_ready) begin
         if (grad_expect.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transaction, expected none actual col %0d row %0d",
                     $time, rsp_out_col, rsp_out_row);
         end else begin
            next_grad = grad_expect.pop_front();
            check_field("grad_x", $signed(next_grad.grad_x), rsp_grad_x);
            check_field("grad_y", $signed(next_grad.grad_y), rsp_grad_y);
            check_field("out_col", next_grad.col, rsp_out_col);
            check_field("out_row", next_grad.row, rsp_out_row);
            check_field("frame_done", next_grad.last, rsp_frame_done);
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (!rsp_stalls_on || $urandom_range(0, 99) < 70) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_hold  <= pick_gap();
         rsp_ready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, grad_expect.size());
         $display("scharr_gradient_stream_core verification failed");
         $finish;
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (!req_ready);
      pixel_count++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (grad_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_FRAME_WIDTH)
         cfg_width = data[WID_W-1:0];
      else if (idx == REG_FRAME_HEIGHT)
         cfg_height = data[ROW_W-1:0];
   endtask

   task automatic set_frame(input logic [CSR_DATA_W-1:0] w_reg, input logic [CSR_DATA_W-1:0] h_reg);
      wait_idle();
      write_csr(REG_FRAME_WIDTH, w_reg);
      write_csr(REG_FRAME_HEIGHT, h_reg);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_frame();
      int w, h, r;
      w = cfg_width;
      h = cfg_height;
      if (w < 2) w = 2;
      if (w > COL_LIMIT) w = COL_LIMIT;
      if (h < 1) h = 1;
      for (int i = 0; i < w * h; i++) begin
         r = $urandom_range(0, 9);
         if (r == 0)
            send_pixel(8'd0);
         else if (r == 1)
            send_pixel(8'd255);
         else
            send_pixel(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_smallest_frame();
      set_frame(12'd2, 12'd2);
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd0);
      send_pixel(8'd255);
   endtask

   task automatic test_single_row();
      set_frame(12'd3, 12'd1);
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd128);
   endtask

   task automatic test_border_mirror();
      set_frame(12'd3, 12'd3);
      for (int i = 0; i < 9; i++)
         send_pixel((i % 2 == 0) ? 8'd255 : 8'd0);
   endtask

   task automatic test_register_extremes();
      set_frame(12'd0, 12'd0);
      send_random_frame();
      set_frame(12'd1, 12'd3);
      send_random_frame();
   endtask

   task automatic test_random_frames();
      int start_count, r, w, h;
      start_count = pixel_count;
      while (pixel_count - start_count < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         w = (r < 70) ? $urandom_range(2, 12) : (r < 90) ? $urandom_range(13, 40)
                                                          : $urandom_range(41, 100);
         h = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
         req_gaps_on   = $urandom_range(0, 3) != 0;
         rsp_stalls_on = $urandom_range(0, 3) != 0;
         set_frame(12'(w), 12'(h));
         send_random_frame();
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_smallest_frame();
      test_single_row();
      test_border_mirror();
      test_register_extremes();
      test_random_frames();
      wait_idle();
      if (grad_expect.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected results never arrived", $time, grad_expect.size());
      end
      if (error_count == 0)
         $display("scharr_gradient_stream_core verification clean");
      else
         $display("scharr_gradient_stream_core verification failed");
      $finish;
   end

endmodule
